FILE: hdl/adde_pkg.sv
// ----------------------------------------------------------------------------
// adde_pkg : shared types, constants and helpers
// Multiply-accumulate operand word, register indexes, exp clipper table and
// rounding helpers for the distortion / echo effect.
// ----------------------------------------------------------------------------
`default_nettype none

package adde_pkg;

   // Shared multiplier operand, product and accumulator widths
   localparam int OP_W   = 30;
   localparam int PROD_W = 2 * OP_W;
   localparam int ACC_W  = PROD_W + 2;

   // Exp clipper table
   localparam int EXP_SIZE  = 256;
   localparam int EXP_IDX_W = $clog2(EXP_SIZE);
   localparam int EXP_W     = 24;

   typedef logic [EXP_W-1:0] exp_rom_type [EXP_SIZE];

   // Register indexes on the csr port
   localparam logic [2:0] CSR_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_MODE      = 3'd1;
   localparam logic [2:0] CSR_DRIVE     = 3'd2;
   localparam logic [2:0] CSR_DIST_MIX  = 3'd3;
   localparam logic [2:0] CSR_BLEND     = 3'd4;
   localparam logic [2:0] CSR_DELAY_MS  = 3'd5;
   localparam logic [2:0] CSR_FEEDBACK  = 3'd6;
   localparam logic [2:0] CSR_DELAY_MIX = 3'd7;

   localparam logic [1:0] MODE_DIST  = 2'd1;
   localparam logic [1:0] MODE_DELAY = 2'd2;

   // One multiply issued to the shared unit
   typedef struct packed {
      logic                   issue;
      logic                   keep;   // add onto the running sum
      logic signed [OP_W-1:0] a;
      logic signed [OP_W-1:0] b;
   } mac_op_type;

   localparam logic signed [ACC_W-1:0] RND16_POS = ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] RND16_NEG = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] RND23_POS = ACC_W'(4194304);
   localparam logic signed [ACC_W-1:0] RND23_NEG = ACC_W'(4194303);

   // round to nearest, ties away from zero
   function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] s;
      s = v + (v[ACC_W-1] ? RND16_NEG : RND16_POS);
      return s >>> 16;
   endfunction

   function automatic logic signed [ACC_W-1:0] rnd23(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] s;
      s = v + (v[ACC_W-1] ? RND23_NEG : RND23_POS);
      return s >>> 23;
   endfunction

   // unsigned quotient by shift and subtract, used only at elaboration
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-k/(N-1)) in Q23 by Taylor series, worked out at elaboration
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] den;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      den = 64'(EXP_SIZE - 1);
      for (int k = 0; k < EXP_SIZE; k++) begin
         term = 64'd1 << 48;
         pos  = term;
         neg  = '0;
         for (int n = 1; n <= 40; n++) begin
            if (term != '0) begin
               term = udiv64(term * 64'(k), den * 64'(n));
               if (n[0]) begin
                  neg = neg + term;
               end else begin
                  pos = pos + term;
               end
            end
         end
         rom[k] = EXP_W'((pos - neg + (64'd1 << 24)) >> 25);
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

FILE: hdl/audio_distortion_delay_effect.sv
// ----------------------------------------------------------------------------
// audio_distortion_delay_effect : clipper distortion / feedback echo
// Q1.23 sample path with bypass, blended step/exp clipper with tone filter,
// or a ring buffer echo, all multiplies on one shared multiply-accumulate.
// ----------------------------------------------------------------------------
//
//  channel | ports                              | moves
//  --------+------------------------------------+------------------------------
//  req     | req_valid/req_ready, sample, last  | one converter word in
//  rsp     | rsp_valid/rsp_ready, sample, last  | one processed word out
//  csr     | csr_wr_en, csr_index, csr_wr_data  | register write, no wait
//
//  Time per word is set by the number of multiplies in a row on the shared
//  unit (each passes issue, product register, accumulate register): bypass
//  uses none, delay fewer than distortion, and distortion more when the
//  gained sample lands in the middle step-clip region.
//  The block takes a new word only from its idle state; a finished word sits
//  in the output register while the next one is taken and processed. A word
//  that finds the output register still full waits in the output state.
//  Reset (synchronous, high) clears control, tone state and write position.
//  The echo store is not cleared: a fill mark (write position plus a wrapped
//  flag) makes never-written entries read as zero, so there is no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_distortion_delay_effect #(
   parameter int DELAY_DEPTH    = 65536,
   parameter int SAMPLE_RATE_HZ = 44100
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_sample_in,
   input  logic               req_last_in_block,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sample_out,
   output logic               rsp_last_out,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_wr_data
);

   localparam int AccW  = adde_pkg::ACC_W;
   localparam int OpW   = adde_pkg::OP_W;
   localparam int AddrW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

   // floor(ms*rate/1000) as (ms*DelayMul) >> 21, exact for 10-bit ms
   localparam logic [63:0] DelayMul = ((64'(SAMPLE_RATE_HZ) << 21) + 64'd999) / 64'd1000;

   localparam logic signed [AccW-1:0] One      = AccW'(8388608);
   localparam logic signed [AccW-1:0] NegOne   = -One;
   localparam logic signed [AccW-1:0] ToneMax  = AccW'(8388607);
   localparam logic signed [AccW-1:0] EchoMax  = AccW'(134217727);
   localparam logic signed [AccW-1:0] EchoMin  = -AccW'(134217728);
   localparam logic signed [AccW-1:0] SqBias   = AccW'(12582912);   // 3*2^22
   localparam logic signed [AccW-1:0] SqRound  = AccW'(25165823);   // 3*2^23-1
   localparam logic signed [AccW-1:0] AccZero  = '0;
   localparam logic [23:0]            OneMag   = 24'h800000;
   localparam logic [16:0]            FracOne  = 17'd65536;
   localparam logic [15:0]            FbMax    = 16'd62259;
   localparam logic [OpW-1:0]         Div3Mul  = OpW'(24'hAAAAAB);
   localparam logic [OpW-1:0]         ToneCoef = OpW'(22938);

   // sequencer
   localparam logic [5:0] ST_IDLE   = 6'd0;
   localparam logic [5:0] ST_G_MUL  = 6'd1;
   localparam logic [5:0] ST_G_W    = 6'd2;
   localparam logic [5:0] ST_G_USE  = 6'd3;
   localparam logic [5:0] ST_T_MUL  = 6'd4;
   localparam logic [5:0] ST_T_W    = 6'd5;
   localparam logic [5:0] ST_T_USE  = 6'd6;
   localparam logic [5:0] ST_Q_MUL  = 6'd7;
   localparam logic [5:0] ST_Q_W    = 6'd8;
   localparam logic [5:0] ST_Q_USE  = 6'd9;
   localparam logic [5:0] ST_P_MUL  = 6'd10;
   localparam logic [5:0] ST_P_W    = 6'd11;
   localparam logic [5:0] ST_P_USE  = 6'd12;
   localparam logic [5:0] ST_F_MUL  = 6'd13;
   localparam logic [5:0] ST_F_W    = 6'd14;
   localparam logic [5:0] ST_F_USE  = 6'd15;
   localparam logic [5:0] ST_B_MUL  = 6'd16;
   localparam logic [5:0] ST_B_MUL2 = 6'd17;
   localparam logic [5:0] ST_B_W    = 6'd18;
   localparam logic [5:0] ST_B_USE  = 6'd19;
   localparam logic [5:0] ST_L_MUL  = 6'd20;
   localparam logic [5:0] ST_L_W    = 6'd21;
   localparam logic [5:0] ST_L_USE  = 6'd22;
   localparam logic [5:0] ST_M_MUL  = 6'd23;
   localparam logic [5:0] ST_M_MUL2 = 6'd24;
   localparam logic [5:0] ST_M_W    = 6'd25;
   localparam logic [5:0] ST_M_USE  = 6'd26;
   localparam logic [5:0] ST_E_MUL  = 6'd27;
   localparam logic [5:0] ST_E_W    = 6'd28;
   localparam logic [5:0] ST_E_USE  = 6'd29;
   localparam logic [5:0] ST_R_RD   = 6'd30;
   localparam logic [5:0] ST_R_USE  = 6'd31;
   localparam logic [5:0] ST_K_MUL  = 6'd32;
   localparam logic [5:0] ST_K_W    = 6'd33;
   localparam logic [5:0] ST_K_USE  = 6'd34;
   localparam logic [5:0] ST_OUT    = 6'd35;

   function automatic logic [16:0] frac_sat(input logic [16:0] v);
      return (v > FracOne) ? FracOne : v;
   endfunction

   function automatic logic signed [24:0] with_sign(input logic neg, input logic [23:0] mag);
      logic signed [24:0] m;
      m = 25'(mag);
      return neg ? -m : m;
   endfunction

   // ---------------- registers ----------------
   logic [5:0]         state_ff, state_in;
   logic               enable_ff, enable_in;
   logic [1:0]         mode_ff, mode_in;
   logic [16:0]        drive_ff, drive_in;
   logic [16:0]        dmix_ff, dmix_in;
   logic [16:0]        blend_ff, blend_in;
   logic [9:0]         dms_ff, dms_in;
   logic [15:0]        fb_ff, fb_in;
   logic [16:0]        emix_ff, emix_in;

   logic signed [23:0] x_ff, x_in;
   logic               last_ff, last_in;
   logic               echo_path_ff, echo_path_in;
   logic               neg_ff, neg_in;
   logic [23:0]        a_ff, a_in;
   logic [22:0]        t_ff, t_in;
   logic [23:0]        w_ff, w_in;
   logic               qzero_ff, qzero_in;
   logic signed [24:0] step_ff, step_in;
   logic [23:0]        ti_ff, ti_in;
   logic [23:0]        diff_ff, diff_in;
   logic [22:0]        f_ff, f_in;
   logic signed [24:0] exp_ff, exp_in;
   logic signed [24:0] c_ff, c_in;
   logic signed [23:0] tone_ff, tone_in;
   logic signed [29:0] y_ff, y_in;
   logic signed [27:0] echo_ff, echo_in;
   logic [AddrW-1:0]   rd_ff, rd_in;
   logic [AddrW-1:0]   wp_ff, wp_in;
   logic               wrapped_ff, wrapped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_last_ff, rsp_last_in;

   // ---------------- shared unit ----------------
   adde_pkg::mac_op_type    mac_op;
   logic signed [AccW-1:0]  acc;

   adde_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .acc   (acc)
   );

   // ---------------- echo store ----------------
   logic        ram_wr_en;
   logic [27:0] ram_wr_data;
   logic [27:0] ram_rd_data;

   adde_ram #(
      .WIDTH (28),
      .DEPTH (DELAY_DEPTH)
   ) u_echo_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_addr (rd_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------- config-derived values ----------------
   logic [16:0] drive_s, dmix_s, blend_s, emix_s, mix_s;
   logic [15:0] fb_s;
   logic [22:0] gain;

   assign drive_s = frac_sat(drive_ff);
   assign dmix_s  = frac_sat(dmix_ff);
   assign blend_s = frac_sat(blend_ff);
   assign emix_s  = frac_sat(emix_ff);
   assign mix_s   = echo_path_ff ? emix_s : dmix_s;
   assign fb_s    = (fb_ff > FbMax) ? FbMax : fb_ff;
   // 1 + 40*d in Q16: 40d = 32d + 8d
   assign gain    = 23'(FracOne) + (23'(drive_s) << 5) + (23'(drive_s) << 3);

   // ---------------- datapath taps off the accumulator ----------------
   logic signed [AccW-1:0]    acc_r16;
   logic signed [AccW-1:0]    g_c;
   logic                      g_neg;
   logic [23:0]               g_mag;
   logic [25:0]               g_x3;
   logic signed [AccW-1:0]    sq_u;
   logic [23:0]               q3;
   logic [adde_pkg::EXP_IDX_W-1:0] e_idx, e_nxt;
   logic [23:0]               e_val;
   logic signed [AccW-1:0]    tone_sum;
   logic signed [AccW-1:0]    echo_new;
   logic [31:0]               d_raw;
   logic [AddrW-1:0]          d_cl;
   logic [AddrW:0]            rd_wrap;
   logic signed [24:0]        y_cl;
   logic signed [32:0]        y_sh;
   logic signed [32:0]        y_out;
   logic signed [25:0]        c_minus_t;

   assign acc_r16 = adde_pkg::rnd16(acc);
   assign g_c     = (acc_r16 > One) ? One : ((acc_r16 < NegOne) ? NegOne : acc_r16);
   assign g_neg   = g_c[AccW-1];
   assign g_mag   = 24'(g_neg ? -g_c : g_c);
   assign g_x3    = 26'(g_mag) + (26'(g_mag) << 1);

   // middle clip region: r = 2^23 - ceil((t^2 - 3*2^22) / (3*2^23))
   assign sq_u    = acc - SqBias;
   assign q3      = 24'(acc >>> 25);

   assign e_idx   = adde_pkg::EXP_IDX_W'(acc >>> 23);
   assign e_nxt   = adde_pkg::EXP_IDX_W'(e_idx + 1'b1);
   assign e_val   = ti_ff - 24'(adde_pkg::rnd23(acc));

   assign c_minus_t = 26'(c_ff) - 26'(tone_ff);
   assign tone_sum  = AccW'(tone_ff) + acc_r16;
   assign echo_new  = AccW'(x_ff) + acc_r16;

   assign d_raw = 32'(acc >>> 21);
   always_comb begin
      if (d_raw > 32'(DELAY_DEPTH - 1)) begin
         d_cl = AddrW'(DELAY_DEPTH - 1);
      end else if (d_raw == '0) begin
         d_cl = AddrW'(1);
      end else begin
         d_cl = AddrW'(d_raw);
      end
   end
   assign rd_wrap = (AddrW + 1)'(wp_ff) + (AddrW + 1)'(DELAY_DEPTH) - (AddrW + 1)'(d_cl);

   // output: y*(2^31-1)/2^23 truncated is 256y-1, 256y+1 or 0
   assign y_cl  = (y_ff > 30'sd8388608) ? 25'sd8388608 :
                  ((y_ff < -30'sd8388608) ? -25'sd8388608 : 25'(y_ff));
   assign y_sh  = 33'(y_cl) <<< 8;
   assign y_out = (y_cl == '0) ? 33'sd0 : (y_cl[24] ? y_sh + 33'sd1 : y_sh - 33'sd1);

   assign ram_wr_en   = (state_ff == ST_K_USE);
   assign ram_wr_data = (echo_new > EchoMax) ? 28'(EchoMax) :
                        ((echo_new < EchoMin) ? 28'(EchoMin) : 28'(echo_new));

   // ---------------- multiplier operand select ----------------
   always_comb begin
      mac_op = '0;
      unique case (state_ff)
         ST_G_MUL: begin
            mac_op.issue = 1'b1;
            mac_op.a     = OpW'(x_ff);
            mac_op.b     = OpW'(gain);
         end
         ST_T_MUL: begin
            mac_op.issue = 1'b1;
            mac_op.a     = OpW'(t_ff);
            mac_op.b     = OpW'(t_ff);
         end
         ST_Q_MUL: begin
            mac_op.issue = 1'b1;
            mac_op.a     = OpW'(w_ff);
            mac_op.b     = Div3Mul;
         end
         ST_P_MUL: begin
            mac_op.issue = 1'b1;
            mac_op.a     = OpW'(a_ff);
            mac_op.b     = OpW'(adde_pkg::EXP_SIZE - 1);
         end
         ST_F_MUL: begin
            mac_op.issue = 1'b1;
            mac_op.a     = OpW'(diff_ff);
            mac_op.b     = OpW'(f_ff);
         end
         ST_B_MUL: begin
            mac_op.issue = 1'b1;
            mac_op.a     = OpW'(step_ff);
            mac_op.b     = OpW'(18'(FracOne) - 18'(blend_s));
         end
         ST_B_MUL2: begin
            mac_op.issue = 1'b1;
            mac_op.keep  = 1'b1;
            mac_op.a     = OpW'(exp_ff);
            mac_op.b     = OpW'(blend_s);
         end
         ST_L_MUL: begin
            mac_op.issue = 1'b1;
            mac_op.a     = OpW'(c_minus_t);
            mac_op.b     = ToneCoef;
         end
         ST_M_MUL: begin
            mac_op.issue = 1'b1;
            mac_op.a     = OpW'(x_ff);
            mac_op.b     = OpW'(18'(FracOne) - 18'(mix_s));
         end
         ST_M_MUL2: begin
            mac_op.issue = 1'b1;
            mac_op.keep  = 1'b1;
            mac_op.a     = echo_path_ff ? OpW'(echo_ff) : OpW'(tone_ff);
            mac_op.b     = OpW'(mix_s);
         end
         ST_E_MUL: begin
            mac_op.issue = 1'b1;
            mac_op.a     = OpW'(dms_ff);
            mac_op.b     = OpW'(DelayMul);
         end
         ST_K_MUL: begin
            mac_op.issue = 1'b1;
            mac_op.a     = OpW'(echo_ff);
            mac_op.b     = OpW'(fb_s);
         end
         default: begin
            mac_op = '0;
         end
      endcase
   end

   // ---------------- sequencer and register next values ----------------
   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      mode_in       = mode_ff;
      drive_in      = drive_ff;
      dmix_in       = dmix_ff;
      blend_in      = blend_ff;
      dms_in        = dms_ff;
      fb_in         = fb_ff;
      emix_in       = emix_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      echo_path_in  = echo_path_ff;
      neg_in        = neg_ff;
      a_in          = a_ff;
      t_in          = t_ff;
      w_in          = w_ff;
      qzero_in      = qzero_ff;
      step_in       = step_ff;
      ti_in         = ti_ff;
      diff_in       = diff_ff;
      f_in          = f_ff;
      exp_in        = exp_ff;
      c_in          = c_ff;
      tone_in       = tone_ff;
      y_in          = y_ff;
      echo_in       = echo_ff;
      rd_in         = rd_ff;
      wp_in         = wp_ff;
      wrapped_in    = wrapped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            adde_pkg::CSR_ENABLE:    enable_in = csr_wr_data[0];
            adde_pkg::CSR_MODE:      mode_in   = csr_wr_data[1:0];
            adde_pkg::CSR_DRIVE:     drive_in  = csr_wr_data;
            adde_pkg::CSR_DIST_MIX:  dmix_in   = csr_wr_data;
            adde_pkg::CSR_BLEND:     blend_in  = csr_wr_data;
            adde_pkg::CSR_DELAY_MS:  dms_in    = csr_wr_data[9:0];
            adde_pkg::CSR_FEEDBACK:  fb_in     = csr_wr_data[15:0];
            adde_pkg::CSR_DELAY_MIX: emix_in   = csr_wr_data;
            default:                 enable_in = enable_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_sample_in[31:8];
               last_in = req_last_in_block;
               if (enable_ff && mode_ff == adde_pkg::MODE_DIST) begin
                  echo_path_in = 1'b0;
                  state_in     = ST_G_MUL;
               end else if (enable_ff && mode_ff == adde_pkg::MODE_DELAY) begin
                  echo_path_in = 1'b1;
                  state_in     = ST_E_MUL;
               end else begin
                  y_in     = 30'($signed(req_sample_in[31:8]));
                  state_in = ST_OUT;
               end
            end
         end

         // pre-gain and clip region
         ST_G_MUL: state_in = ST_G_W;
         ST_G_W:   state_in = ST_G_USE;
         ST_G_USE: begin
            neg_in = g_neg;
            a_in   = g_mag;
            t_in   = 23'(26'(1 << 24) - g_x3);
            if (g_x3 <= 26'(1 << 23)) begin
               step_in   = with_sign(g_neg, {g_mag[22:0], 1'b0});
               state_in  = ST_P_MUL;
            end else if (g_x3 <= 26'(1 << 24)) begin
               state_in  = ST_T_MUL;
            end else begin
               step_in   = with_sign(g_neg, OneMag);
               state_in  = ST_P_MUL;
            end
         end

         // step clipper middle region
         ST_T_MUL: state_in = ST_T_W;
         ST_T_W:   state_in = ST_T_USE;
         ST_T_USE: begin
            qzero_in = (sq_u <= AccZero);
            w_in     = 24'((sq_u + SqRound) >>> 23);
            state_in = ST_Q_MUL;
         end
         ST_Q_MUL: state_in = ST_Q_W;
         ST_Q_W:   state_in = ST_Q_USE;
         ST_Q_USE: begin
            step_in  = with_sign(neg_ff, qzero_ff ? OneMag : OneMag - q3);
            state_in = ST_P_MUL;
         end

         // exp clipper: table index and fraction
         ST_P_MUL: state_in = ST_P_W;
         ST_P_W:   state_in = ST_P_USE;
         ST_P_USE: begin
            ti_in = adde_pkg::EXP_ROM[e_idx];
            if (e_idx == adde_pkg::EXP_IDX_W'(adde_pkg::EXP_SIZE - 1)) begin
               diff_in = '0;
            end else begin
               diff_in = adde_pkg::EXP_ROM[e_idx] - adde_pkg::EXP_ROM[e_nxt];
            end
            f_in     = 23'(acc);
            state_in = ST_F_MUL;
         end
         ST_F_MUL: state_in = ST_F_W;
         ST_F_W:   state_in = ST_F_USE;
         ST_F_USE: begin
            exp_in   = with_sign(neg_ff, OneMag - e_val);
            state_in = ST_B_MUL;
         end

         // shape blend
         ST_B_MUL:  state_in = ST_B_MUL2;
         ST_B_MUL2: state_in = ST_B_W;
         ST_B_W:    state_in = ST_B_USE;
         ST_B_USE: begin
            c_in     = 25'(acc_r16);
            state_in = ST_L_MUL;
         end

         // one-pole tone filter
         ST_L_MUL: state_in = ST_L_W;
         ST_L_W:   state_in = ST_L_USE;
         ST_L_USE: begin
            if (tone_sum > ToneMax) begin
               tone_in = 24'(ToneMax);
            end else if (tone_sum < NegOne) begin
               tone_in = 24'(NegOne);
            end else begin
               tone_in = 24'(tone_sum);
            end
            state_in = ST_M_MUL;
         end

         // dry/wet mix, shared by both effects
         ST_M_MUL:  state_in = ST_M_MUL2;
         ST_M_MUL2: state_in = ST_M_W;
         ST_M_W:    state_in = ST_M_USE;
         ST_M_USE: begin
            y_in     = 30'(acc_r16);
            state_in = ST_OUT;
         end

         // echo: delay length and read address
         ST_E_MUL: state_in = ST_E_W;
         ST_E_W:   state_in = ST_E_USE;
         ST_E_USE: begin
            if (wp_ff >= d_cl) begin
               rd_in = wp_ff - d_cl;
            end else begin
               rd_in = AddrW'(rd_wrap);
            end
            state_in = ST_R_RD;
         end
         ST_R_RD: state_in = ST_R_USE;
         ST_R_USE: begin
            // entry never written reads as zero
            echo_in  = (wrapped_ff || rd_ff < wp_ff) ? signed'(ram_rd_data) : 28'sd0;
            state_in = ST_K_MUL;
         end
         ST_K_MUL: state_in = ST_K_W;
         ST_K_W:   state_in = ST_K_USE;
         ST_K_USE: begin
            // store write happens this cycle
            if (wp_ff == AddrW'(DELAY_DEPTH - 1)) begin
               wp_in      = '0;
               wrapped_in = 1'b1;
            end else begin
               wp_in = wp_ff + 1'b1;
            end
            state_in = ST_M_MUL;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = 32'(y_out);
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         mode_ff      <= '0;
         drive_ff     <= '0;
         dmix_ff      <= '0;
         blend_ff     <= '0;
         dms_ff       <= '0;
         fb_ff        <= '0;
         emix_ff      <= '0;
         tone_ff      <= '0;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         mode_ff      <= mode_in;
         drive_ff     <= drive_in;
         dmix_ff      <= dmix_in;
         blend_ff     <= blend_in;
         dms_ff       <= dms_in;
         fb_ff        <= fb_in;
         emix_ff      <= emix_in;
         tone_ff      <= tone_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      last_ff       <= last_in;
      echo_path_ff  <= echo_path_in;
      neg_ff        <= neg_in;
      a_ff          <= a_in;
      t_ff          <= t_in;
      w_ff          <= w_in;
      qzero_ff      <= qzero_in;
      step_ff       <= step_in;
      ti_ff         <= ti_in;
      diff_ff       <= diff_in;
      f_ff          <= f_in;
      exp_ff        <= exp_in;
      c_ff          <= c_in;
      y_ff          <= y_in;
      echo_ff       <= echo_in;
      rd_ff         <= rd_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last_out   = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/adde_ram.sv
// ----------------------------------------------------------------------------
// adde_ram : generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module adde_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 65536
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/adde_mac.sv
// ----------------------------------------------------------------------------
// adde_mac : shared multiply-accumulate unit
// Registered product, then registered accumulate; an issued multiply reaches
// the sum through the product register and then the accumulate register.
// ----------------------------------------------------------------------------
`default_nettype none

module adde_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  adde_pkg::mac_op_type                op,
   output logic signed [adde_pkg::ACC_W-1:0]   acc
);

   localparam logic signed [adde_pkg::ACC_W-1:0] AccZero = '0;

   logic signed [adde_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [adde_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic                               pv_ff, pv_in;
   logic                               keep_ff, keep_in;

   always_comb begin
      prod_in = adde_pkg::PROD_W'(op.a) * adde_pkg::PROD_W'(op.b);
      pv_in   = op.issue;
      keep_in = op.keep;
      acc_in  = acc_ff;
      if (pv_ff) begin
         acc_in = (keep_ff ? acc_ff : AccZero) + adde_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
      end
      keep_ff <= keep_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

FILE: hdl/adde_checker.sv
// ----------------------------------------------------------------------------
// adde_checker : port-level checks for the effect block
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module adde_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic signed [31:0] req_sample_in,
   input logic               req_last_in_block,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_sample_out,
   input logic               rsp_last_out,
   input logic               csr_wr_en,
   input logic [2:0]         csr_index,
   input logic [16:0]        csr_wr_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
                                  && $stable(rsp_last_out))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // one word in flight: busy after each accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken twice in a row");

   // output scaling is symmetric, most negative code never appears
   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_out != 32'sh80000000)
      else $error("result word at most negative code");

endmodule

bind audio_distortion_delay_effect adde_checker u_adde_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : distortion / echo effect testbench
// Drives converter words through every path and many register settings,
// predicts each processed word with a cycle-free model of the effect and checks it.
// ----------------------------------------------------------------------------

// Predicts processed words and holds them until the block returns them.
class effect_scoreboard;
   localparam int DEPTH = 65536;
   localparam int RATE  = 44100;
   localparam longint ONE23 = 64'sd8388608;
   localparam longint ONE16 = 64'sd65536;

   longint exp_table [256];
   longint echo_mem [DEPTH];
   int unsigned wr_pos;
   longint tone;
   longint unsigned regs [8];
   logic [32:0] expected_words [$];   // {last, sample}
   int errors;

   function new();
      bit [63:0] term, pos, neg;
      for (int k = 0; k < 256; k++) begin
         term = 64'd1 << 48;
         pos  = term;
         neg  = 0;
         for (int n = 1; n <= 40 && term != 0; n++) begin
            term = term * k / (64'd255 * n);
            if (n % 2) neg += term;
            else pos += term;
         end
         exp_table[k] = longint'((pos - neg + (64'd1 << 24)) >> 25);
      end
      foreach (echo_mem[i]) echo_mem[i] = 0;
      foreach (regs[i]) regs[i] = 0;
      wr_pos = 0;
      tone   = 0;
      errors = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [16:0] val);
      int w;
      case (idx)
         adde_pkg::CSR_ENABLE:   w = 1;
         adde_pkg::CSR_MODE:     w = 2;
         adde_pkg::CSR_DELAY_MS: w = 10;
         adde_pkg::CSR_FEEDBACK: w = 16;
         default:                w = 17;
      endcase
      regs[idx] = longint'(val) & ((64'd1 << w) - 1);
   endfunction

   function longint rnd(longint v, int sh);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
      return v < 0 ? -m : m;
   endfunction

   function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function longint frac(int idx);
      return regs[idx] > ONE16 ? ONE16 : longint'(regs[idx]);
   endfunction

   function longint step_shape(longint g);
      longint a, r, num;
      a = g < 0 ? -g : g;
      if (3 * a <= ONE23) r = 2 * a;
      else if (3 * a <= 2 * ONE23) begin
         num = -9 * a * a + 12 * a * ONE23 - (64'sd1 <<< 46);
         r = (num + (3 * ONE23) / 2) / (3 * ONE23);
      end else r = ONE23;
      return g < 0 ? -r : r;
   endfunction

   function longint exp_shape(longint g);
      longint a, p, i, f, e, r;
      a = g < 0 ? -g : g;
      p = a * 255;
      i = p >>> 23;
      f = p & 64'h7FFFFF;
      if (i >= 255) e = exp_table[255];
      else e = exp_table[i] - (((exp_table[i] - exp_table[i+1]) * f + (64'sd1 <<< 22)) >>> 23);
      r = ONE23 - e;
      return g < 0 ? -r : r;
   endfunction

   function longint distort(longint x);
      longint g, c, s, m;
      s = frac(4);
      m = frac(3);
      g = clip(rnd(x * (ONE16 + 40 * frac(2)), 16), -ONE23, ONE23);
      c = rnd(step_shape(g) * (ONE16 - s) + exp_shape(g) * s, 16);
      tone = clip(tone + rnd((c - tone) * 22938, 16), -ONE23, ONE23 - 1);
      return rnd(x * (ONE16 - m) + tone * m, 16);
   endfunction

   function longint echo_path(longint x);
      longint d, fb, m, echo;
      int unsigned rd;
      d  = longint'(regs[5]) * RATE / 1000;
      fb = regs[6] > 62259 ? 62259 : longint'(regs[6]);
      m  = frac(7);
      if (d > DEPTH - 1) d = DEPTH - 1;
      if (d < 1) d = 1;
      rd = (wr_pos + DEPTH - int'(d)) % DEPTH;
      echo = echo_mem[rd];
      echo_mem[wr_pos] = clip(x + rnd(echo * fb, 16), -(64'sd1 <<< 27), (64'sd1 <<< 27) - 1);
      wr_pos = (wr_pos + 1) % DEPTH;
      return rnd(x * (ONE16 - m) + echo * m, 16);
   endfunction

   // accepted converter word: work out the processed word it causes
   function void note_input(logic [31:0] word, logic last);
      longint x, y;
      logic [31:0] o;
      x = longint'($signed(word[31:8]));
      y = x;
      if (regs[0][0]) begin
         if (regs[1] == adde_pkg::MODE_DIST) y = distort(x);
         else if (regs[1] == adde_pkg::MODE_DELAY) y = echo_path(x);
      end
      y = clip(y, -ONE23, ONE23);
      o = 32'(y * 2147483647 / ONE23);
      expected_words.push_back({last, o});
   endfunction

   function void check_result(logic [31:0] sample, logic last);
      logic [32:0] exp_word;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected word sample=%h last=%b", $time, sample, last);
         errors++;
         return;
      end
      exp_word = expected_words.pop_front();
      if (sample !== exp_word[31:0]) begin
         $display("%0t: sample mismatch expected %h actual %h", $time, exp_word[31:0], sample);
         errors++;
      end
      if (last !== exp_word[32]) begin
         $display("%0t: last mismatch expected %b actual %b", $time, exp_word[32], last);
         errors++;
      end
   endfunction
endclass

module tb;

   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 5000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [31:0] req_sample_in = 0;
   logic req_last_in_block = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_sample_out;
   logic rsp_last_out;
   logic csr_wr_en = 0;
   logic [2:0] csr_index = 0;
   logic [16:0] csr_wr_data = 0;

   effect_scoreboard effect_sb = new();
   bit no_idle = 0;          // stretch with both sides running flat out
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   audio_distortion_delay_effect DUT (.*);

   // result side: random back-pressure, check every accepted word
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) effect_sb.check_result(rsp_sample_out, rsp_last_out);
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= 20);
      end
   end

   // watchdog: nothing moving on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("** audio_distortion_delay_effect: FAILED **");
         $finish;
      end
   end

   task automatic send_word(logic [31:0] word, logic last);
      while (!no_idle && $urandom_range(0, 99) < 20) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_sample_in <= word;
      req_last_in_block <= last;
      do @(posedge clock); while (!req_ready);
      effect_sb.note_input(word, last);
   endtask

   // let the pipe drain before touching registers
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (effect_sb.expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [16:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      effect_sb.write_reg(idx, val);
   endtask

   task automatic configure(logic en, logic [1:0] mode, logic [16:0] drive, logic [16:0] dmix,
                            logic [16:0] blend, logic [16:0] ms, logic [16:0] fb,
                            logic [16:0] emix);
      drain();
      csr_write(adde_pkg::CSR_ENABLE, en);
      csr_write(adde_pkg::CSR_MODE, mode);
      csr_write(adde_pkg::CSR_DRIVE, drive);
      csr_write(adde_pkg::CSR_DIST_MIX, dmix);
      csr_write(adde_pkg::CSR_BLEND, blend);
      csr_write(adde_pkg::CSR_DELAY_MS, ms);
      csr_write(adde_pkg::CSR_FEEDBACK, fb);
      csr_write(adde_pkg::CSR_DELAY_MIX, emix);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return 32'($signed($urandom) >>> $urandom_range(1, 16));
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom) >>> $urandom_range(4, 10));
      endcase
   endfunction

   task automatic random_words(int n);
      repeat (n) send_word(pick_word(), $urandom_range(0, 3) == 0);
   endtask

   // same full-scale word over and over: pushes tone and echo to saturation
   task automatic constant_words(logic [31:0] word, int n);
      repeat (n) send_word(word, 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // registers at reset: plain pass-through
      send_word(32'h7FFF_FFFF, 1);
      send_word(32'h8000_0000, 0);
      send_word(32'h0000_0000, 1);
      send_word(32'hFFFF_FF00, 0);
      send_word(32'h0000_00FF, 1);

      configure(0, adde_pkg::MODE_DIST, 65536, 65536, 0, 0, 0, 0);
      random_words(100);
      configure(1, MODE_NONE, 0, 0, 0, 0, 0, 0);
      random_words(60);
      configure(1, MODE_UNUSED, 0, 0, 0, 0, 0, 0);
      random_words(60);

      // step clipper region edges at unity gain
      configure(1, adde_pkg::MODE_DIST, 0, 65536, 0, 0, 0, 0);
      send_word(32'(24'sd2796202) << 8, 0);
      send_word(32'(24'sd2796203) << 8, 0);
      send_word(32'(24'sd5592405) << 8, 0);
      send_word(32'(24'sd5592406) << 8, 0);
      send_word(32'(-24'sd2796203) << 8, 1);
      send_word(32'(-24'sd5592406) << 8, 0);
      random_words(150);

      configure(1, adde_pkg::MODE_DIST, 65536, 65536, 65536, 0, 0, 0);
      constant_words(32'h7FFF_FF00, 20);
      constant_words(32'h8000_0000, 20);
      random_words(150);

      // oversized fractions saturate
      configure(1, adde_pkg::MODE_DIST, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 0, 0, 0);
      random_words(120);
      configure(1, adde_pkg::MODE_DIST, 20000, 30000, 45000, 0, 0, 0);
      random_words(150);

      // shortest echo with top feedback: store overflow
      configure(1, adde_pkg::MODE_DELAY, 0, 0, 0, 0, 62259, 65536);
      constant_words(32'h7FFF_FFFF, 50);
      constant_words(32'h8000_0000, 80);
      random_words(100);
      configure(1, adde_pkg::MODE_DELAY, 0, 0, 0, 1, 16'hFFFF, 17'h1FFFF);
      random_words(200);
      configure(1, adde_pkg::MODE_DELAY, 0, 0, 0, 2, $urandom_range(0, 65535),
                $urandom_range(0, 65536));
      random_words(200);
      configure(1, adde_pkg::MODE_DELAY, 0, 0, 0, 1023, 30000, 32768);
      random_words(100);
      configure(1, adde_pkg::MODE_DELAY, 0, 0, 0, 1000, 62259, 0);
      random_words(60);

      // random settings, part of it with no idling at all
      for (int p = 0; p < 4; p++) begin
         configure($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 131071),
                   $urandom_range(0, 131071), $urandom_range(0, 131071),
                   $urandom_range(0, 3), $urandom_range(0, 65535), $urandom_range(0, 131071));
         no_idle = (p == 2);
         random_words(60);
      end
      no_idle = 0;

      req_valid <= 0;
      while (effect_sb.expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (effect_sb.errors == 0) begin
         $display("** audio_distortion_delay_effect: PASSED **");
      end else begin
         $display("** audio_distortion_delay_effect: FAILED **");
      end
      $finish;
   end
endmodule
